// ----- rtl/cnaf_pkg.sv -----
// ----------------------------------------------------------------------------
// cnaf_pkg
// Shared types, constants and helpers for the next-alarm finder.
// ----------------------------------------------------------------------------
package cnaf_pkg;

  localparam int RULE_SLOTS = 6;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  localparam int MIN_W  = 60;
  localparam int HOUR_W = 24;
  localparam int DAY_W  = 32;
  localparam int MON_W  = 12;
  localparam int WDAY_W = 7;
  localparam int SECS_W = 15;
  localparam int CHUNKS = 8;   // minute mask searched as 8 chunks of 8 bits

  typedef struct packed {
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [WDAY_W-1:0] weekday;
    logic [SECS_W-1:0] seconds;
    logic              mono;
  } rule_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_STORED  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NORULES = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ENC,
    ST_CMP,
    ST_WRAP,
    ST_OUT
  } state_e;

  // Two BCD digits to binary
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Binary 0..99 to two BCD digits; tens by reciprocal multiply
  function automatic logic [7:0] bcd_enc(input logic [6:0] n);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  units;
    p     = 15'(n) * 15'd205;
    tens  = 4'(p >> 11);
    units = n - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

// ----- rtl/cnaf_rule_store.sv -----
// ----------------------------------------------------------------------------
// cnaf_rule_store
// Rule table: one write port, one read port at the scan index.
// ----------------------------------------------------------------------------
module cnaf_rule_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [cnaf_pkg::IDX_W-1:0]    waddr_i,
  input  cnaf_pkg::rule_t               wdata_i,
  input  logic [cnaf_pkg::IDX_W-1:0]    raddr_i,
  output cnaf_pkg::rule_t               rdata_o
);
  import cnaf_pkg::*;

  rule_t mem_q [RULE_SLOTS];

  // contents undefined until written; only slots below the count are read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[raddr_i];

endmodule

// ----- rtl/cron_rule_next_alarm_finder.sv -----
// ----------------------------------------------------------------------------
// cron_rule_next_alarm_finder
// Cron-style rule table with a next-alarm search over the stored rules.
// ----------------------------------------------------------------------------
// Sequencing: a load beat, or a query on an empty table, goes from acceptance
//   straight to the output state; a query with stored rules passes fetch,
//   encode and compare for each rule, then wrap, then the output state.
// Throughput: one beat at a time; the next input is taken once the result is
//   in the output register. Rate is set by the single rule scan unit, which
//   spends fetch, chunk encode and compare states on each rule in turn.
// Reset: clears the sequencer, the rule count and the output valid; the rule
//   table itself is not cleared.
// ----------------------------------------------------------------------------
module cron_rule_next_alarm_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [59:0] minute_mask_i,
  input  logic [23:0] hour_mask_i,
  input  logic [31:0] day_mask_i,
  input  logic [11:0] month_mask_i,
  input  logic [6:0]  weekday_mask_i,
  input  logic [14:0] record_seconds_i,
  input  logic        record_mono_i,
  input  logic [39:0] clock_bcd_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  wait_minutes_o,
  output logic [6:0]  alarm_minute_o,
  output logic [5:0]  alarm_hour_o,
  output logic [2:0]  alarm_weekday_o,
  output logic [14:0] chosen_duration_o,
  output logic        chosen_mono_o,
  output logic [2:0]  chosen_rule_o
);
  import cnaf_pkg::*;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic              out_valid_q;

  logic [IDX_W-1:0]  idx_q;         // rule under scan
  status_e           pend_status_q; // kind of result being built

  // decoded clock; minute/hour/weekday are reused for the wrapped alarm time
  logic [5:0]        minute_q;
  logic [4:0]        hour_q;
  logic [2:0]        wday_q;        // 0-based, Sunday 0
  logic [4:0]        day_q;
  logic              day_v_q;
  logic [3:0]        month_q;
  logic              month_v_q;

  // scan unit pipeline registers
  logic [MIN_W-1:0]  sh_q;          // minute mask aligned to current minute
  logic              match_q;       // day and hour both match
  logic [SECS_W-1:0] cand_secs_q;
  logic              cand_mono_q;
  logic [CHUNKS-1:0] chunk_nz_q;
  logic [2:0]        chunk_pos_q [CHUNKS];

  // running best
  logic [5:0]        best_wait_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [SECS_W-1:0] best_secs_q;
  logic              best_mono_q;

  // output register
  logic [1:0]        o_status_q;
  logic [5:0]        o_wait_q;
  logic [6:0]        o_min_q;
  logic [5:0]        o_hour_q;
  logic [2:0]        o_wday_q;
  logic [14:0]       o_secs_q;
  logic              o_mono_q;
  logic [2:0]        o_rule_q;

  // --------------------------------------------------------------------------
  // Rule table
  // --------------------------------------------------------------------------
  logic   store_we;
  rule_t  wr_rule;
  rule_t  rd_rule;
  logic   full;

  assign full = (count_q == CNT_W'(RULE_SLOTS));

  assign wr_rule = '{minute:  minute_mask_i,
                     hour:    hour_mask_i,
                     day:     day_mask_i,
                     month:   month_mask_i,
                     weekday: weekday_mask_i,
                     seconds: record_seconds_i,
                     mono:    record_mono_i};

  cnaf_rule_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_rule),
    .raddr_i (idx_q),
    .rdata_o (rd_rule)
  );

  // --------------------------------------------------------------------------
  // Sequencer control
  // --------------------------------------------------------------------------
  logic in_take;
  logic out_load;
  logic last_rule;

  assign last_rule = (CNT_W'(idx_q) == count_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (mode_i && count_q != '0) ? ST_FETCH : ST_OUT;
        end
      end
      ST_FETCH: state_d = ST_ENC;
      ST_ENC:   state_d = ST_CMP;
      ST_CMP:   state_d = last_rule ? ST_WRAP : ST_FETCH;
      ST_WRAP:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_take    = in_valid_i && (state_q == ST_IDLE);
    store_we   = in_take && !mode_i && !full;
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (store_we) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clock decode (at acceptance)
  // --------------------------------------------------------------------------
  logic [7:0] dec_min, dec_hour, dec_wd, dec_day, dec_mon;

  always_comb begin
    dec_min  = bcd_dec(clock_bcd_i[7:0]);
    dec_hour = bcd_dec(clock_bcd_i[15:8]);
    dec_wd   = bcd_dec(clock_bcd_i[23:16]);
    dec_day  = bcd_dec(clock_bcd_i[31:24]);
    dec_mon  = bcd_dec(clock_bcd_i[39:32]);
  end

  // --------------------------------------------------------------------------
  // Scan unit: fetch/align, chunk encode, compare
  // --------------------------------------------------------------------------
  logic              day_ok;
  logic [63:0]       sh_pad;
  logic [CHUNKS-1:0] enc_nz;
  logic [2:0]        enc_pos [CHUNKS];
  logic              hit;
  logic [5:0]        hit_pos;
  logic [5:0]        cand_wait;
  logic [6:0]        wrap_sum;

  always_comb begin
    if (rd_rule.weekday != '0) begin
      day_ok = rd_rule.weekday[wday_q];
    end else begin
      day_ok = month_v_q && day_v_q && rd_rule.month[month_q] && rd_rule.day[day_q];
    end
  end

  // per-chunk lowest set bit, chunks independent
  always_comb begin
    sh_pad = {4'd0, sh_q};
    for (int c = 0; c < CHUNKS; c++) begin
      enc_nz[c]  = |sh_pad[c*8 +: 8];
      enc_pos[c] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (sh_pad[c*8 + j]) begin
          enc_pos[c] = 3'(j);
        end
      end
    end
  end

  // first non-empty chunk wins
  always_comb begin
    hit     = 1'b0;
    hit_pos = 6'd0;
    for (int c = CHUNKS - 1; c >= 0; c--) begin
      if (chunk_nz_q[c]) begin
        hit     = 1'b1;
        hit_pos = {3'(c), chunk_pos_q[c]};
      end
    end
    cand_wait = (match_q && hit) ? hit_pos : (6'd60 - minute_q);
  end

  assign wrap_sum = {1'b0, minute_q} + {1'b0, best_wait_q};

  // alarm time back to BCD for the output register
  logic [7:0] enc_min;
  logic [7:0] enc_hour;

  assign enc_min  = bcd_enc({1'b0, minute_q});
  assign enc_hour = bcd_enc({2'b0, hour_q});

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          idx_q       <= '0;
          best_wait_q <= 6'd61;
          best_idx_q  <= count_q[IDX_W-1:0];
          if (mode_i) begin
            pend_status_q <= (count_q == '0) ? STAT_NORULES : STAT_DONE;
          end else begin
            pend_status_q <= full ? STAT_FULL : STAT_STORED;
          end
          minute_q  <= (dec_min > 8'd59) ? 6'd59 : dec_min[5:0];
          hour_q    <= (dec_hour > 8'd23) ? 5'd23 : dec_hour[4:0];
          if (dec_wd < 8'd1) begin
            wday_q <= 3'd0;
          end else if (dec_wd > 8'd7) begin
            wday_q <= 3'd6;
          end else begin
            wday_q <= 3'(dec_wd - 8'd1);
          end
          day_v_q   <= (dec_day >= 8'd1) && (dec_day <= 8'd32);
          day_q     <= (dec_day >= 8'd1 && dec_day <= 8'd32) ? 5'(dec_day - 8'd1) : 5'd0;
          month_v_q <= (dec_mon >= 8'd1) && (dec_mon <= 8'd12);
          month_q   <= (dec_mon >= 8'd1 && dec_mon <= 8'd12) ? 4'(dec_mon - 8'd1) : 4'd0;
        end
      end
      ST_FETCH: begin
        sh_q        <= rd_rule.minute >> minute_q;
        match_q     <= day_ok && rd_rule.hour[hour_q];
        cand_secs_q <= rd_rule.seconds;
        cand_mono_q <= rd_rule.mono;
      end
      ST_ENC: begin
        chunk_nz_q  <= enc_nz;
        chunk_pos_q <= enc_pos;
      end
      ST_CMP: begin
        // strict less-than keeps the earliest rule on a tie
        if (cand_wait < best_wait_q) begin
          best_wait_q <= cand_wait;
          best_idx_q  <= idx_q;
          best_secs_q <= cand_secs_q;
          best_mono_q <= cand_mono_q;
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      ST_WRAP: begin
        if (wrap_sum >= 7'd60) begin
          minute_q <= 6'(wrap_sum - 7'd60);
          if (hour_q == 5'd23) begin
            hour_q <= 5'd0;
            wday_q <= (wday_q == 3'd6) ? 3'd0 : wday_q + 3'd1;
          end else begin
            hour_q <= hour_q + 5'd1;
          end
        end else begin
          minute_q <= wrap_sum[5:0];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          o_status_q <= pend_status_q;
          if (pend_status_q == STAT_DONE) begin
            o_wait_q <= best_wait_q;
            o_min_q  <= enc_min[6:0];
            o_hour_q <= enc_hour[5:0];
            o_wday_q <= wday_q + 3'd1;
            o_secs_q <= best_secs_q;
            o_mono_q <= best_mono_q;
          end else begin
            o_wait_q <= '0;
            o_min_q  <= '0;
            o_hour_q <= '0;
            o_wday_q <= '0;
            o_secs_q <= '0;
            o_mono_q <= 1'b0;
          end
          if (pend_status_q == STAT_DONE || pend_status_q == STAT_STORED) begin
            o_rule_q <= 3'(best_idx_q);
          end else begin
            o_rule_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign wait_minutes_o    = o_wait_q;
  assign alarm_minute_o    = o_min_q;
  assign alarm_hour_o      = o_hour_q;
  assign alarm_weekday_o   = o_wday_q;
  assign chosen_duration_o = o_secs_q;
  assign chosen_mono_o     = o_mono_q;
  assign chosen_rule_o     = o_rule_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RULE_SLOTS))
    else $error("rule count above table size");

  a_store_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> count_q < CNT_W'(RULE_SLOTS))
    else $error("rule written into a full table");

  a_wait_in_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRAP |-> best_wait_q <= 6'd60 - minute_q)
    else $error("best wait runs past the top of the hour");

  a_chosen_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && pend_status_q == STAT_DONE) |-> CNT_W'(best_idx_q) < count_q)
    else $error("chosen rule not in table");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cron rule next-alarm finder. A directed table
// fills the rule store and walks the corner cases. A long random run of
// queries against the full table follows. Every result beat is checked
// field by field against a hand-written expectation or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;

  import cnaf_pkg::*;

  localparam int RANDOM_QUERIES = 800;
  localparam int QUIET_LIMIT    = 1000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 25;    // slack for a full-table query to finish

  // one input beat, as presented on the ports
  typedef struct packed {
    logic        mode;
    rule_t       rule;
    logic [39:0] clock;
  } beat_t;

  // one result beat; field order follows the output ports
  typedef struct packed {
    status_e     status;
    logic [5:0]  wait_min;
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [2:0]  weekday;
    logic [14:0] duration;
    logic        mono;
    logic [2:0]  rule_idx;
  } alarm_t;

  typedef struct {
    beat_t  beat;
    bit     typed;   // expectation written by hand in the table
    alarm_t exp;
  } plan_row_t;

  // ports
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        mode_i           = 1'b0;
  logic [59:0] minute_mask_i    = '0;
  logic [23:0] hour_mask_i      = '0;
  logic [31:0] day_mask_i       = '0;
  logic [11:0] month_mask_i     = '0;
  logic [6:0]  weekday_mask_i   = '0;
  logic [14:0] record_seconds_i = '0;
  logic        record_mono_i    = 1'b0;
  logic [39:0] clock_bcd_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  wait_minutes_o;
  logic [6:0]  alarm_minute_o;
  logic [5:0]  alarm_hour_o;
  logic [2:0]  alarm_weekday_o;
  logic [14:0] chosen_duration_o;
  logic        chosen_mono_o;
  logic [2:0]  chosen_rule_o;

  // predictor copy of the rule store
  rule_t  rules [RULE_SLOTS];
  int     n_rules = 0;

  plan_row_t plan_q[$];
  alarm_t    pending_alarms_q[$];

  bit gaps_on      = 1'b0;   // random idling on both channels
  int errors       = 0;
  int quiet_cycles = 0;
  int loads_in     = 0;
  int queries_in   = 0;
  int results_seen = 0;
  int fired_now    = 0;      // queries answered with a zero wait
  int refused      = 0;      // loads bounced off a full table or empty queries

  cron_rule_next_alarm_finder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .minute_mask_i     (minute_mask_i),
    .hour_mask_i       (hour_mask_i),
    .day_mask_i        (day_mask_i),
    .month_mask_i      (month_mask_i),
    .weekday_mask_i    (weekday_mask_i),
    .record_seconds_i  (record_seconds_i),
    .record_mono_i     (record_mono_i),
    .clock_bcd_i       (clock_bcd_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .wait_minutes_o    (wait_minutes_o),
    .alarm_minute_o    (alarm_minute_o),
    .alarm_hour_o      (alarm_hour_o),
    .alarm_weekday_o   (alarm_weekday_o),
    .chosen_duration_o (chosen_duration_o),
    .chosen_mono_o     (chosen_mono_o),
    .chosen_rule_o     (chosen_rule_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // BCD helpers, two digits per byte
  // --------------------------------------------------------------------------
  function automatic int bcd_to_bin(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] bin_to_bcd(input int n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  // --------------------------------------------------------------------------
  // Alarm predictor. Loads update the local rule store; queries scan it.
  // --------------------------------------------------------------------------
  function automatic alarm_t next_alarm(input beat_t b);
    alarm_t a;
    int     mi, hr, wd, dy, mo;
    int     r, m, w, best, best_wait;
    bit     day_ok;
    a = '0;
    if (b.mode == 1'b0) begin
      if (n_rules >= RULE_SLOTS) begin
        a.status = STAT_FULL;
        return a;
      end
      rules[n_rules] = b.rule;
      a.status   = STAT_STORED;
      a.rule_idx = 3'(n_rules);
      n_rules++;
      return a;
    end
    if (n_rules == 0) begin
      a.status = STAT_NORULES;
      return a;
    end

    // decode and clamp the clock; weekday made zero-based
    mi = bcd_to_bin(b.clock[7:0]);
    hr = bcd_to_bin(b.clock[15:8]);
    wd = bcd_to_bin(b.clock[23:16]);
    dy = bcd_to_bin(b.clock[31:24]);
    mo = bcd_to_bin(b.clock[39:32]);
    if (mi > 59) mi = 59;
    if (hr > 23) hr = 23;
    if (wd < 1) wd = 1;
    if (wd > 7) wd = 7;
    wd = wd - 1;
    dy = (dy >= 1 && dy <= 32) ? dy - 1 : 255;
    mo = (mo >= 1 && mo <= 12) ? mo - 1 : 255;

    best      = 0;
    best_wait = 61;
    for (r = 0; r < n_rules; r++) begin
      w = 60 - mi;
      if (rules[r].weekday != '0)
        day_ok = rules[r].weekday[wd];
      else
        day_ok = mo < 12 && dy < 32 && rules[r].month[mo] && rules[r].day[dy];
      if (day_ok && rules[r].hour[hr]) begin
        // walk down so the earliest set minute wins
        for (m = 59; m >= mi; m--)
          if (rules[r].minute[m]) w = m - mi;
      end
      if (w < best_wait) begin
        best_wait = w;
        best      = r;
      end
    end

    mi += best_wait;
    if (mi >= 60) begin
      mi -= 60;
      hr++;
      if (hr >= 24) begin
        hr = 0;
        wd++;
        if (wd >= 7) wd = 0;
      end
    end

    a.status   = STAT_DONE;
    a.wait_min = 6'(best_wait);
    a.minute   = 7'(bin_to_bcd(mi));
    a.hour     = 6'(bin_to_bcd(hr));
    a.weekday  = 3'(wd + 1);
    a.duration = rules[best].seconds;
    a.mono     = rules[best].mono;
    a.rule_idx = 3'(best);
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Table and stimulus builders
  // --------------------------------------------------------------------------
  function automatic beat_t load_beat(input logic [59:0] mi, input logic [23:0] hr,
                                      input logic [31:0] dy, input logic [11:0] mo,
                                      input logic [6:0] wd, input logic [14:0] secs,
                                      input logic mono);
    beat_t b;
    b = '0;
    b.rule = '{minute: mi, hour: hr, day: dy, month: mo, weekday: wd,
               seconds: secs, mono: mono};
    return b;
  endfunction

  function automatic beat_t query_beat(input logic [39:0] clock);
    beat_t b;
    b       = '0;
    b.mode  = 1'b1;
    b.clock = clock;
    return b;
  endfunction

  function automatic alarm_t status_only(input status_e s, input int idx);
    alarm_t a;
    a          = '0;
    a.status   = s;
    a.rule_idx = 3'(idx);
    return a;
  endfunction

  function automatic alarm_t done_alarm(input int wt, input logic [6:0] mi,
                                        input logic [5:0] hr, input logic [2:0] wd,
                                        input logic [14:0] dur, input logic mono,
                                        input int idx);
    alarm_t a;
    a = '{status: STAT_DONE, wait_min: 6'(wt), minute: mi, hour: hr, weekday: wd,
          duration: dur, mono: mono, rule_idx: 3'(idx)};
    return a;
  endfunction

  function automatic void add_row(input beat_t b, input bit typed, input alarm_t exp);
    plan_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.exp   = exp;
    plan_q.push_back(row);
  endfunction

  // Random clock: mostly legal times, some out-of-range days and months,
  // some raw bytes, and a bias toward the end of the hour and day for wraps.
  function automatic logic [39:0] random_clock();
    logic [7:0] mi, hr, wd, dy, mo;
    int         sel;
    sel = $urandom_range(99);
    if (sel < 8)
      return {8'($urandom), 32'($urandom)};
    mi = bin_to_bcd($urandom_range(59));
    hr = bin_to_bcd($urandom_range(23));
    wd = bin_to_bcd($urandom_range(7, 1));
    dy = bin_to_bcd($urandom_range(31, 1));
    mo = bin_to_bcd($urandom_range(12, 1));
    if (sel < 16) begin
      dy = bin_to_bcd(($urandom_range(1) != 0) ? 32 : 0);
      mo = bin_to_bcd(($urandom_range(1) != 0) ? 13 : 0);
    end else if (sel < 36) begin
      // the mid-June rule
      dy = 8'h15;
      mo = 8'h06;
    end
    if ($urandom_range(9) == 0) begin
      mi = 8'h59;
      hr = 8'h23;
    end else if ($urandom_range(9) == 0) begin
      hr = 8'h00;
    end
    return {mo, dy, wd, hr, mi};
  endfunction

  // --------------------------------------------------------------------------
  // Input side: present one beat, idling at random first, and book the
  // expectation at the edge where the beat is taken.
  // --------------------------------------------------------------------------
  task automatic drive_beat(input beat_t b, input bit typed, input alarm_t exp);
    alarm_t predicted;
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= b.mode;
    minute_mask_i    <= b.rule.minute;
    hour_mask_i      <= b.rule.hour;
    day_mask_i       <= b.rule.day;
    month_mask_i     <= b.rule.month;
    weekday_mask_i   <= b.rule.weekday;
    record_seconds_i <= b.rule.seconds;
    record_mono_i    <= b.rule.mono;
    clock_bcd_i      <= b.clock;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // predictor always runs so its rule store tracks the block
    predicted = next_alarm(b);
    pending_alarms_q.push_back(typed ? exp : predicted);
    if (b.mode) queries_in++;
    else loads_in++;
  endtask

  // Output side: random stall, off during the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 6);
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t tb: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    alarm_t got;
    alarm_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, wait_minutes_o, alarm_minute_o, alarm_hour_o, alarm_weekday_o,
             chosen_duration_o, chosen_mono_o, chosen_rule_o};
      if (pending_alarms_q.size() == 0) begin
        errors++;
        $display("%0t tb: unexpected result beat, got %0h", $time, got);
      end else begin
        want = pending_alarms_q.pop_front();
        results_seen++;
        if (want.status == STAT_DONE && want.wait_min == '0) fired_now++;
        if (want.status == STAT_FULL || want.status == STAT_NORULES) refused++;
        check_field("status",   want.status,   got.status);
        check_field("wait",     want.wait_min, got.wait_min);
        check_field("minute",   want.minute,   got.minute);
        check_field("hour",     want.hour,     got.hour);
        check_field("weekday",  want.weekday,  got.weekday);
        check_field("duration", want.duration, got.duration);
        check_field("mono",     want.mono,     got.mono);
        check_field("rule",     want.rule_idx, got.rule_idx);
      end
    end
  end

  // Watchdog: too long with no beat moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    beat_t b;
    int    n;
    int    n_queries;

    // Directed table. Rule plan:
    //   0  all masks clear, never matches
    //   1  everything set but only hour 23, longest duration, mono
    //   2  weekends, 08-11h, quarter past / half past / quarter to
    //   3  15 June only, every hour, minutes 0 and 59
    //   4  every weekday, midnight hour, odd minutes
    //   5  Monday to Friday, 01-22h, every ten minutes
    add_row(query_beat(40'h01_01_01_00_00), 1'b1, status_only(STAT_NORULES, 0));
    add_row(load_beat('0, '0, '0, '0, '0, '0, 1'b0), 1'b1, status_only(STAT_STORED, 0));
    // lone dead rule: sleep to the top of the hour
    add_row(query_beat(40'h01_01_01_00_00), 1'b1,
            done_alarm(60, 7'h00, 6'h01, 3'd1, 15'd0, 1'b0, 0));
    add_row(load_beat(60'hfff_ffff_ffff_ffff, 24'h80_0000, 32'hffff_ffff, 12'hfff,
                      7'h00, 15'h7fff, 1'b1), 1'b1, status_only(STAT_STORED, 1));
    // last minute of the year, record now
    add_row(query_beat(40'h12_31_07_23_59), 1'b1,
            done_alarm(0, 7'h59, 6'h23, 3'd7, 15'h7fff, 1'b1, 1));
    add_row(query_beat(40'h12_32_07_23_30), 1'b0, '0);   // day 32 still legal
    add_row(query_beat(40'h00_15_03_23_10), 1'b0, '0);   // month zero
    add_row(query_beat(40'h13_00_00_22_05), 1'b0, '0);   // month 13, day 0, weekday 0
    add_row(query_beat(40'hff_ff_ff_ff_ff), 1'b0, '0);   // every digit saturates
    add_row(load_beat(60'h0000_2000_4000_8000, 24'h00_0f00, 32'h0, 12'h0,
                      7'b100_0001, 15'd1800, 1'b0), 1'b1, status_only(STAT_STORED, 2));
    add_row(query_beat(40'h03_14_07_09_20), 1'b0, '0);
    add_row(query_beat(40'h03_14_01_10_45), 1'b0, '0);
    add_row(load_beat(60'h800_0000_0000_0001, 24'hff_ffff, 32'h0000_4000, 12'h020,
                      7'h00, 15'd600, 1'b1), 1'b1, status_only(STAT_STORED, 3));
    add_row(query_beat(40'h06_15_02_23_59), 1'b0, '0);   // tie, first rule wins
    add_row(query_beat(40'h06_15_02_14_30), 1'b0, '0);
    add_row(load_beat(60'haaa_aaaa_aaaa_aaaa, 24'h00_0001, 32'h5555_5555, 12'h555,
                      7'h7f, 15'd60, 1'b0), 1'b1, status_only(STAT_STORED, 4));
    add_row(query_beat(40'h01_01_04_00_01), 1'b0, '0);
    add_row(load_beat(60'h004_0100_4010_0401, 24'h7f_fffe, 32'haaaa_aaaa, 12'haaa,
                      7'h3e, 15'd3600, 1'b1), 1'b1, status_only(STAT_STORED, 5));
    add_row(query_beat(40'h02_28_06_12_07), 1'b0, '0);
    // table full: loads bounce with every field at both extremes
    add_row(load_beat('1, '1, '1, '1, '1, '1, 1'b1), 1'b1, status_only(STAT_FULL, 0));
    add_row(load_beat('0, '0, '0, '0, '0, '0, 1'b0), 1'b1, status_only(STAT_FULL, 0));
    b      = query_beat(40'h12_31_01_23_59);
    b.rule = '1;                                        // ignored on a query
    add_row(b, 1'b0, '0);
    add_row(query_beat(40'h09_30_07_23_58), 1'b0, '0);
    add_row(query_beat(40'h00_00_00_00_00), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni  <= 1'b1;
    gaps_on <= 1'b1;

    foreach (plan_q[i]) drive_beat(plan_q[i].beat, plan_q[i].typed, plan_q[i].exp);

    // Random part: queries against the full table, a few bounced loads
    // carrying random rule bits. A quiet stretch in the middle.
    n_queries = 0;
    for (n = 0; n_queries < RANDOM_QUERIES; n++) begin
      if (n == 250) gaps_on <= 1'b0;
      if (n == 420) gaps_on <= 1'b1;
      b.mode         = ($urandom_range(99) >= 5);
      b.rule.minute  = 60'({$urandom, $urandom});
      b.rule.hour    = 24'($urandom);
      b.rule.day     = $urandom;
      b.rule.month   = 12'($urandom);
      b.rule.weekday = 7'($urandom);
      b.rule.seconds = 15'($urandom);
      b.rule.mono    = 1'($urandom);
      b.clock        = random_clock();
      if (b.mode) n_queries++;
      drive_beat(b, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // drain, then give the block its worst-case latency
    while (pending_alarms_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_alarms_q.size() != 0) begin
      errors++;
      $display("%0t tb: %0d results never arrived", $time, pending_alarms_q.size());
    end

    $display("tb: %0d loads and %0d queries sent, %0d results compared",
             loads_in, queries_in, results_seen);
    $display("tb: %0d alarms due at once, %0d loads or queries refused, %0d errors",
             fired_now, refused, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cnaf_pkg.sv
rtl/cnaf_rule_store.sv
rtl/cron_rule_next_alarm_finder.sv
test/tb.sv
